@@ rtl/core/pga_pkg.sv @@
// Shared constants and types for the pairwise gravity acceleration pipeline.
// No dependencies.
package pga_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int COORD_W           = 32;
  localparam int MASS_W            = 48;
  localparam int COUP_W            = 32;
  localparam int ACC_W             = 32;
  localparam logic [COUP_W-1:0] COUPLING_RESET = 32'd1231135700;

  localparam int SQRT_FRAC = 32;
  localparam int MAG_W     = COORD_W + 1;          // |d| up to 2^32 - 1
  localparam int SQ_W      = 2 * MAG_W;            // one squared offset
  localparam int SUM_W     = SQ_W;                 // 3 * 2^64 still fits
  localparam int X_W       = SUM_W + 2 * SQRT_FRAC; // radicand
  localparam int ROOT_W    = X_W / 2;
  localparam int CM_W      = COUP_W + MASS_W;
  localparam int DEN0_W    = SUM_W + ROOT_W;
  localparam int NUM0_W    = CM_W + MAG_W;
  localparam int QUO_W     = ACC_W;

  typedef struct packed {
    logic [SUM_W-1:0]           sum;
    logic [CM_W-1:0]            cm;
    logic [2:0][MAG_W-1:0]      mag;
    logic [2:0]                 neg;
  } sqc_t;

endpackage

@@ rtl/core/pga_if.sv @@
// Channel interfaces: input beat, result beat and coupling write.
// Depends on pga_pkg.
interface pga_in_if import pga_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] target_z;
  logic signed [COORD_W-1:0] source_x;
  logic signed [COORD_W-1:0] source_y;
  logic signed [COORD_W-1:0] source_z;
  logic [MASS_W-1:0]         source_mass;
  modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, source_mass, input ready);
  modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                source_z, source_mass, output ready);
endinterface

interface pga_out_if import pga_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;
  logic                    distance_zero;
  logic                    saturated;
  modport source (output valid, accel_x, accel_y, accel_z, distance_zero, saturated,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, distance_zero, saturated,
                output ready);
endinterface

interface pga_cfg_if import pga_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COUP_W-1:0] grav_coupling;
  modport source (output valid, grav_coupling, input ready);
  modport sink (input valid, grav_coupling, output ready);
endinterface

@@ rtl/core/pairwise_gravity_acceleration.sv @@
// Top level: pipelined Newtonian pair acceleration, one pair per unstalled cycle.
// Depends on pga_pkg and the channel interfaces in pga_if.sv.
//
// Usage:
//   in_bus  : one beat per body pair (target and source positions, source mass).
//   out_bus : one beat per input beat, same order: accel_x/y/z (signed,
//             POS_FRAC_BITS fraction bits, saturated), distance_zero, saturated.
//   cfg_bus : writes grav_coupling (G * tick, units of 2^-64); always ready.
//             Write only while the pipe is empty.
// The bit-serial square root (one root bit per stage, 65 stages) and the
// per-axis restoring division (one quotient bit per stage, 32 stages) make
// up most of the register stages between input beat and result beat.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset empties the pipe (all valid bits cleared) and loads the default
// coupling. When the receiver stalls the whole pipe freezes: in_bus.ready
// follows out_bus.ready whenever the output register holds a beat, so no
// beat is lost or repeated.
module pairwise_gravity_acceleration import pga_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pga_cfg_if.sink   cfg_bus,
  pga_in_if.sink    in_bus,
  pga_out_if.source out_bus
);

  // numerator / denominator alignment: q = C*M*|d|*2^A / (S*R*2^B)
  localparam int A     = (3 * POS_FRAC_BITS > SQRT_FRAC) ? 3 * POS_FRAC_BITS - SQRT_FRAC : 0;
  localparam int B     = (3 * POS_FRAC_BITS < SQRT_FRAC) ? SQRT_FRAC - 3 * POS_FRAC_BITS : 0;
  localparam int NUM_W = NUM0_W + A;
  localparam int DEN_W = DEN0_W + B;
  localparam int DV_W  = (NUM_W > DEN_W + QUO_W + 1) ? NUM_W : DEN_W + QUO_W + 1;
  localparam int N_SQ  = ROOT_W;
  localparam int N_DV  = QUO_W;
  localparam int NV    = 7 + N_SQ + N_DV;   // total register stages
  localparam int I_OUT = NV - 1;

  // ---------------------------------------------------------------- config
  logic [COUP_W-1:0] coup_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coup_r <= COUPLING_RESET;
    end else if (cfg_bus.valid) begin
      coup_r <= cfg_bus.grav_coupling;
    end
  end

  // ---------------------------------------------------------------- control
  // Valid bits shift with the data; whole pipe holds while the output stalls.
  logic [NV-1:0] vld_r;
  logic          adv;

  assign adv          = !vld_r[I_OUT] || out_bus.ready;
  assign in_bus.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_bus.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // offsets d = source - target, split into magnitude and sign
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0]        mag  [3];
  logic [2:0]              neg;

  always_comb begin
    diff[0] = MAG_W'(in_bus.source_x) - MAG_W'(in_bus.target_x);
    diff[1] = MAG_W'(in_bus.source_y) - MAG_W'(in_bus.target_y);
    diff[2] = MAG_W'(in_bus.source_z) - MAG_W'(in_bus.target_z);
    for (int i = 0; i < 3; i++) begin
      neg[i] = diff[i][MAG_W-1];
      mag[i] = neg[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
    end
  end

  logic [2:0][MAG_W-1:0] s1_mag_r;
  logic [2:0]            s1_neg_r;
  logic [MASS_W-1:0]     s1_mass_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s1_mag_r[i] <= mag[i];
      s1_neg_r  <= neg;
      s1_mass_r <= in_bus.source_mass;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // squares, coupling * mass in two halves
  localparam int MH = MASS_W / 2;

  logic [SQ_W-1:0]         s2_sq_r [3];
  logic [COUP_W+MH-1:0]    s2_cml_r;
  logic [COUP_W+MH-1:0]    s2_cmh_r;
  logic [2:0][MAG_W-1:0]   s2_mag_r;
  logic [2:0]              s2_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s2_sq_r[i] <= SQ_W'(s1_mag_r[i] * s1_mag_r[i]);
      s2_cml_r <= (COUP_W+MH)'(coup_r * s1_mass_r[MH-1:0]);
      s2_cmh_r <= (COUP_W+MH)'(coup_r * s1_mass_r[MASS_W-1:MH]);
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  sqc_t s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r.sum <= SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]) + SUM_W'(s2_sq_r[2]);
      s3_r.cm  <= CM_W'(s2_cml_r) + (CM_W'(s2_cmh_r) << MH);
      s3_r.mag <= s2_mag_r;
      s3_r.neg <= s2_neg_r;
    end
  end

  // ---------------------------------------------------------------- sqrt
  // R = floor(sqrt(S * 2^64)), one root bit per stage, MSB first
  logic [X_W-1:0]    sr_rem_r  [N_SQ];
  logic [ROOT_W-1:0] sr_root_r [N_SQ];
  sqc_t              sr_c_r    [N_SQ];

  for (genvar j = 0; j < N_SQ; j++) begin : g_sqrt
    localparam int K = N_SQ - 1 - j;
    logic [X_W-1:0]    rem_in;
    logic [ROOT_W-1:0] root_in;
    sqc_t              c_in;
    logic [X_W:0]      trial;
    logic [X_W-1:0]    rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = X_W'(s3_r.sum) << (2 * SQRT_FRAC);
      assign root_in = '0;
      assign c_in    = s3_r;
    end else begin : g_next
      assign rem_in  = sr_rem_r[j-1];
      assign root_in = sr_root_r[j-1];
      assign c_in    = sr_c_r[j-1];
    end

    always_comb begin
      trial    = ((X_W+1)'(root_in) << (K + 1)) | ((X_W+1)'(1) << (2 * K));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if ((X_W+1)'(rem_in) >= trial) begin
        rem_nxt  = X_W'((X_W+1)'(rem_in) - trial);
        root_nxt = root_in | (ROOT_W'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_rem_r[j]  <= rem_nxt;
        sr_root_r[j] <= root_nxt;
        sr_c_r[j]    <= c_in;
      end
    end
  end

  // ---------------------------------------------------------------- mult 1
  // partial products of S*R and cm*|d_i|
  localparam int SL = SUM_W / 2;
  localparam int RL = SL;
  localparam int CW = 32;
  localparam int PP_W = SL + RL;

  sqc_t              sq_last;
  logic [ROOT_W-1:0] r_last;
  logic [PP_W-1:0]   m1_p_r  [4];
  logic [CW+MAG_W-1:0] m1_np_r [3][3];
  logic [2:0]        m1_neg_r;
  logic              m1_zero_r;

  assign sq_last = sr_c_r[N_SQ-1];
  assign r_last  = sr_root_r[N_SQ-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p_r[0] <= PP_W'(sq_last.sum[SL-1:0] * r_last[RL-1:0]);
      m1_p_r[1] <= PP_W'(sq_last.sum[SL-1:0] * r_last[ROOT_W-1:RL]);
      m1_p_r[2] <= PP_W'(sq_last.sum[SUM_W-1:SL] * r_last[RL-1:0]);
      m1_p_r[3] <= PP_W'(sq_last.sum[SUM_W-1:SL] * r_last[ROOT_W-1:RL]);
      for (int i = 0; i < 3; i++) begin
        m1_np_r[i][0] <= (CW+MAG_W)'(sq_last.cm[CW-1:0] * sq_last.mag[i]);
        m1_np_r[i][1] <= (CW+MAG_W)'(sq_last.cm[2*CW-1:CW] * sq_last.mag[i]);
        m1_np_r[i][2] <= (CW+MAG_W)'(sq_last.cm[CM_W-1:2*CW] * sq_last.mag[i]);
      end
      m1_neg_r  <= sq_last.neg;
      m1_zero_r <= (sq_last.sum == '0);
    end
  end

  // ---------------------------------------------------------------- mult 2
  logic [DEN0_W-1:0] den0;
  logic [NUM0_W-1:0] num0 [3];

  always_comb begin
    den0 = DEN0_W'(m1_p_r[0]) + (DEN0_W'(m1_p_r[1]) << RL) +
           (DEN0_W'(m1_p_r[2]) << SL) + (DEN0_W'(m1_p_r[3]) << (SL + RL));
    for (int i = 0; i < 3; i++) begin
      num0[i] = NUM0_W'(m1_np_r[i][0]) + (NUM0_W'(m1_np_r[i][1]) << CW) +
                (NUM0_W'(m1_np_r[i][2]) << (2 * CW));
    end
  end

  logic [NUM_W-1:0] m2_num_r [3];
  logic [DEN_W-1:0] m2_den_r;
  logic [2:0]       m2_neg_r;
  logic             m2_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) m2_num_r[i] <= NUM_W'(num0[i]) << A;
      m2_den_r  <= DEN_W'(den0) << B;
      m2_neg_r  <= m1_neg_r;
      m2_zero_r <= m1_zero_r;
    end
  end

  // ---------------------------------------------------------------- divide
  // index 0: overflow check (quotient >= 2^32); then one quotient bit per stage
  logic [NUM_W-1:0] dv_rem_r  [N_DV+1][3];
  logic [QUO_W-1:0] dv_q_r    [N_DV+1][3];
  logic [2:0]       dv_ovf_r  [N_DV+1];
  logic [DEN_W-1:0] dv_den_r  [N_DV+1];
  logic [2:0]       dv_neg_r  [N_DV+1];
  logic             dv_zero_r [N_DV+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= m2_num_r[i];
        dv_q_r[0][i]   <= '0;
        dv_ovf_r[0][i] <= DV_W'(m2_num_r[i]) >= (DV_W'(m2_den_r) << QUO_W);
      end
      dv_den_r[0]  <= m2_den_r;
      dv_neg_r[0]  <= m2_neg_r;
      dv_zero_r[0] <= m2_zero_r;
    end
  end

  for (genvar j = 1; j <= N_DV; j++) begin : g_div
    localparam int QB = N_DV - j;
    logic [DV_W-1:0]  dsh;
    logic [NUM_W-1:0] rem_nxt [3];
    logic [QUO_W-1:0] q_nxt   [3];

    always_comb begin
      dsh = DV_W'(dv_den_r[j-1]) << QB;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = dv_rem_r[j-1][i];
        q_nxt[i]   = dv_q_r[j-1][i];
        if (DV_W'(dv_rem_r[j-1][i]) >= dsh) begin
          rem_nxt[i] = NUM_W'(DV_W'(dv_rem_r[j-1][i]) - dsh);
          q_nxt[i]   = dv_q_r[j-1][i] | (QUO_W'(1) << QB);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= rem_nxt[i];
          dv_q_r[j][i]   <= q_nxt[i];
        end
        dv_ovf_r[j]  <= dv_ovf_r[j-1];
        dv_den_r[j]  <= dv_den_r[j-1];
        dv_neg_r[j]  <= dv_neg_r[j-1];
        dv_zero_r[j] <= dv_zero_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  // clip magnitude to 2^31-1 (toward +) or 2^31 (toward -), then apply sign
  logic [QUO_W:0]   lim   [3];
  logic [QUO_W:0]   qv    [3];
  logic [2:0]       clip;
  logic [ACC_W-1:0] acc_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]  = dv_neg_r[N_DV][i] ? ((QUO_W+1)'(1) << (QUO_W - 1))
                                  : ((QUO_W+1)'(1) << (QUO_W - 1)) - 1'b1;
      qv[i]   = (QUO_W+1)'(dv_q_r[N_DV][i]);
      clip[i] = dv_ovf_r[N_DV][i] || (qv[i] > lim[i]);
      if (clip[i]) qv[i] = lim[i];
      acc_nxt[i] = dv_neg_r[N_DV][i] ? ACC_W'(-qv[i]) : ACC_W'(qv[i]);
    end
  end

  logic [ACC_W-1:0] acc_r [3];
  logic             dz_r;
  logic             sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_zero_r[N_DV]) begin
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
        dz_r  <= 1'b1;
        sat_r <= 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
        dz_r  <= 1'b0;
        sat_r <= |clip;
      end
    end
  end

  assign out_bus.valid         = vld_r[I_OUT];
  assign out_bus.accel_x       = acc_r[0];
  assign out_bus.accel_y       = acc_r[1];
  assign out_bus.accel_z       = acc_r[2];
  assign out_bus.distance_zero = dz_r;
  assign out_bus.saturated     = sat_r;

endmodule

@@ tb/pga_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for pairwise_gravity_acceleration: watches the three channels,
// predicts each result beat and compares it. Depends on pga_pkg and pga_if.sv.
module pga_checker import pga_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pga_cfg_if   cfg_mon,
  pga_in_if    in_mon,
  pga_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int F     = POS_FRAC_BITS_DEF;
  localparam int SH_N  = (3 * F > SQRT_FRAC) ? 3 * F - SQRT_FRAC : 0;
  localparam int SH_D  = (3 * F < SQRT_FRAC) ? SQRT_FRAC - 3 * F : 0;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic                    dzero;
    logic                    sat;
  } accel_t;

  logic [COUP_W-1:0] coupling;
  accel_t            accel_q[$];

  function automatic logic [65:0] isqrt(input logic [255:0] x);
    logic [255:0] root;
    logic [255:0] trial;
    root = '0;
    for (int i = 65; i >= 0; i--) begin
      trial = root | (256'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root[65:0];
  endfunction

  function automatic accel_t predict_accel(
    input logic signed [31:0] tx, ty, tz, sx, sy, sz,
    input logic [MASS_W-1:0] mass, input logic [COUP_W-1:0] coup);
    logic signed [32:0] d[3];
    logic [255:0]       mag[3];
    logic [255:0]       s, den, num, q, lim;
    logic [31:0]        comp[3];
    accel_t             res;
    d[0] = {sx[31], sx} - {tx[31], tx};
    d[1] = {sy[31], sy} - {ty[31], ty};
    d[2] = {sz[31], sz} - {tz[31], tz};
    s = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? 256'(-d[i]) : 256'(d[i]);
      s = s + mag[i] * mag[i];
    end
    res = '0;
    if (s == 0) begin
      res.dzero = 1'b1;
      return res;
    end
    den = (s * 256'(isqrt(s << (2 * SQRT_FRAC)))) << SH_D;
    for (int i = 0; i < 3; i++) begin
      num = (256'(coup) * 256'(mass) * mag[i]) << SH_N;
      q = num / den;
      lim = d[i] < 0 ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (q > lim) begin
        q = lim;
        res.sat = 1'b1;
      end
      comp[i] = d[i] < 0 ? 32'(-q[31:0]) : q[31:0];
    end
    res.ax = comp[0];
    res.ay = comp[1];
    res.az = comp[2];
    return res;
  endfunction

  assign pending = accel_q.size();

  always @(posedge clk) begin
    accel_t got, want;
    if (!rst_n) begin
      coupling   <= COUPLING_RESET;
      fail_count <= 0;
      accel_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) coupling <= cfg_mon.grav_coupling;
      if (in_mon.valid && in_mon.ready)
        accel_q.push_back(predict_accel(in_mon.target_x, in_mon.target_y, in_mon.target_z,
                                        in_mon.source_x, in_mon.source_y, in_mon.source_z,
                                        in_mon.source_mass, coupling));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.accel_x, out_mon.accel_y, out_mon.accel_z,
                out_mon.distance_zero, out_mon.saturated};
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = accel_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h dz=%b sat=%b", $time,
                     want.ax, want.ay, want.az, want.dzero, want.sat);
            $display("%0t:          act x=%h y=%h z=%h dz=%b sat=%b", $time,
                     got.ax, got.ay, got.az, got.dzero, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/pairwise_gravity_acceleration_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for pairwise_gravity_acceleration: clock, reset, stimulus,
// receiver stalls and verdict. Depends on pga_pkg, pga_if.sv, pga_checker.
module pairwise_gravity_acceleration_tb;
  import pga_pkg::*;

  localparam int IDLE_LIMIT = 5000;   // cycles with no beat on any channel
  localparam int TAIL       = 120;    // a bit over the pipeline depth
  localparam int LONG_HOLD  = 400;    // long enough to fill the pipe

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pga_cfg_if cfg_bus ();
  pga_in_if  in_bus ();
  pga_out_if out_bus ();

  int  fail_count;
  int  pending;
  int  idle_cycles = 0;
  bit  hold_req    = 1'b0;  // stimulus asks the receiver for one long hold-off
  bit  burst       = 1'b0;  // no new random gaps on either side while set

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.grav_coupling = '0;
    in_bus.valid = 1'b0;
    in_bus.target_x = '0; in_bus.target_y = '0; in_bus.target_z = '0;
    in_bus.source_x = '0; in_bus.source_y = '0; in_bus.source_z = '0;
    in_bus.source_mass = '0;
    out_bus.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pairwise_gravity_acceleration uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  pga_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_mon    (cfg_bus),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // receiver: random stalls, mostly short, a few long; one forced long hold
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (burst || $urandom_range(0, 3) != 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end
    end
  end

  // one beat; valid stays high when the next beat follows with no gap
  task automatic send_pair(input logic [31:0] tx, ty, tz, sx, sy, sz,
                           input logic [47:0] mass);
    int gap;
    gap = burst ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.target_x <= tx; in_bus.target_y <= ty; in_bus.target_z <= tz;
    in_bus.source_x <= sx; in_bus.source_y <= sy; in_bus.source_z <= sz;
    in_bus.source_mass <= mass;
    in_bus.valid <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // only with the pipe drained; every pair yields a beat, so empty queue is idle
  task automatic write_coupling(input logic [31:0] coup);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL) @(posedge clk);
    cfg_bus.grav_coupling <= coup;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // source offset on one axis: equal, small, medium or anything
  function automatic logic [31:0] offset_axis(input logic [31:0] t);
    case ($urandom_range(0, 9))
      0:       return t;
      1, 2, 3: return t + ($urandom_range(0, 1) ? 32'(1) << $urandom_range(0, 20)
                                               : -(32'(1) << $urandom_range(0, 20)));
      4, 5, 6: return t + ($urandom() >> $urandom_range(4, 16)) -
                          ($urandom() >> $urandom_range(4, 16));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random;
    logic [31:0] tx, ty, tz;
    logic [47:0] mass;
    tx = $urandom(); ty = $urandom(); tz = $urandom();
    mass = {$urandom(), 16'($urandom())} >> $urandom_range(0, 47);
    if ($urandom_range(0, 40) == 0)
      send_pair(tx, ty, tz, tx, ty, tz, mass);           // coincident
    else
      send_pair(tx, ty, tz, offset_axis(tx), offset_axis(ty), offset_axis(tz), mass);
  endtask

  initial begin
    logic [31:0] settings[5];
    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1231135700, 32'h0};
    settings[4] = $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at the reset coupling
    send_pair(0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);                 // coincident
    send_pair(0, 0, 0, 32'h0001_0000, 0, 0, 48'd1000);               // unit offset on x
    send_pair(0, 0, 0, 0, 32'hFFFF_0000, 0, 48'hFFFF_FFFF_FFFF);     // unit offset on -y, full mass
    send_pair(0, 0, 0, 0, 0, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);     // tiny +z offset
    send_pair(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);     // tiny -z offset
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 48'd1);
    send_pair(0, 0, 0, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 48'd0); // zero mass
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
              32'h1235_5678, 32'h9ABC_DEF0, 32'h0F0E_0F0F, 48'h0000_3B9A_CA00);
    send_pair(0, 0, 0, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 48'h0010_0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
              32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
    send_pair(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0, 48'h5555_5555_5555);

    // sweep couplings; the first setting zeroes every result
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_coupling(settings[ph - 1]);
      for (int n = 0; n < 258; n++) begin
        burst = (n >= 100 && n < 140);
        if (ph == 2 && n == 60) hold_req = 1'b1;  // pipe fills behind this hold
        if (ph == 3 && n == 130) begin
          in_bus.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
        end
        send_random();
      end
      burst = 1'b0;
    end
    in_bus.valid <= 1'b0;

    wait (pending == 0);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pga_pkg.sv
rtl/core/pga_if.sv
rtl/core/pairwise_gravity_acceleration.sv
tb/pga_checker.sv
tb/pairwise_gravity_acceleration_tb.sv
